FILE: src/dual_calendar_day_advance_assert.svh
// assertion macros for the dual calendar day advance block
`ifndef DUAL_CALENDAR_DAY_ADVANCE_ASSERT_SVH
`define DUAL_CALENDAR_DAY_ADVANCE_ASSERT_SVH

// same-cycle implication, off during reset
`define DCDA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define DCDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/dcda_pkg.sv
// types, constants and calendar functions for the dual calendar day advance block
`default_nettype none

package dcda_pkg;

  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned STATUS_W = 3;

  localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
  localparam logic [YEAR_W-1:0]  YEAR_RST   = 14'd1401;
  localparam logic [MONTH_W-1:0] MONTH_RST  = 4'd1;
  localparam logic [DAY_W-1:0]   DAY_RST    = 5'd1;
  localparam logic [MONTH_W-1:0] MONTH_LAST = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_ONE  = 4'd1;
  localparam logic [DAY_W-1:0]   DAY_ONE    = 5'd1;

  // jalali leap rule: ((y + 12) mod 33) mod 4 == 1
  localparam logic [YEAR_W:0] JAL_OFFSET = 15'd12;
  localparam logic [6:0]      JAL_CYCLE  = 7'd33;
  localparam logic [6:0]      JAL_CYCLE2 = 7'd66;

  // 25 * 7209 == 1 mod 2^14, so y is a multiple of 25 when y * 7209 mod 2^14 <= 655
  localparam logic [YEAR_W-1:0] INV25       = 14'd7209;
  localparam logic [YEAR_W-1:0] DIV25_LIMIT = 14'd655;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_MONTH = 3'd1,
    ST_BAD_DAY   = 3'd2,
    ST_DAY_LARGE = 3'd3,
    ST_LEAP_DAY  = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_e;

  typedef enum logic {
    CAL_JALALI    = 1'b0,
    CAL_GREGORIAN = 1'b1
  } cal_kind_e;

  typedef enum logic {
    ACT_LOAD    = 1'b0,
    ACT_ADVANCE = 1'b1
  } action_e;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  typedef struct packed {
    action_e            action;
    logic [YEAR_W-1:0]  load_year;
    logic [MONTH_W-1:0] load_month;
    logic [DAY_W-1:0]   load_day;
  } item_t;

  typedef struct packed {
    logic    we;
    date_t   date;
    status_e status;
  } step_t;

  function automatic logic jalali_leap(input logic [YEAR_W-1:0] y);
    logic [YEAR_W:0] t;
    logic [6:0]      s;
    logic [6:0]      r;
    t = {1'b0, y} + JAL_OFFSET;
    // 32 == -1 mod 33: fold the three 5-bit digits with alternating sign
    s = 7'(t[4:0]) + 7'(t[14:10]) + JAL_CYCLE - 7'(t[9:5]);
    if (s >= JAL_CYCLE2) begin
      r = s - JAL_CYCLE2;
    end else if (s >= JAL_CYCLE) begin
      r = s - JAL_CYCLE;
    end else begin
      r = s;
    end
    return r[1:0] == 2'b01;
  endfunction

  function automatic logic greg_leap(input logic [YEAR_W-1:0] y);
    logic [YEAR_W-1:0] p;
    logic              div25;
    logic              div4;
    logic              div16;
    p     = y * INV25;
    div25 = p <= DIV25_LIMIT;
    div4  = y[1:0] == 2'b00;
    div16 = y[3:0] == 4'b0000;
    return (div4 && !div25) || (div16 && div25);
  endfunction

  function automatic logic [DAY_W-1:0] common_len(input cal_kind_e cal,
                                                  input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    if (cal == CAL_JALALI) begin
      if (m <= 4'd6) begin
        len = 5'd31;
      end else if (m <= 4'd11) begin
        len = 5'd30;
      end else begin
        len = 5'd29;
      end
    end else begin
      case (m)
        4'd2:                       len = 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
        default:                    len = 5'd31;
      endcase
    end
    return len;
  endfunction

  function automatic logic leap_month(input cal_kind_e cal, input logic [MONTH_W-1:0] m);
    return (cal == CAL_JALALI) ? (m == MONTH_LAST) : (m == 4'd2);
  endfunction

  function automatic logic has_leap_day(input cal_kind_e cal,
                                        input logic [YEAR_W-1:0] y,
                                        input logic [MONTH_W-1:0] m);
    logic leap;
    leap = (cal == CAL_JALALI) ? jalali_leap(y) : greg_leap(y);
    return leap_month(cal, m) && leap;
  endfunction

endpackage

`default_nettype wire

FILE: src/dcda_if.sv
// valid/ready channel interfaces for items, results and the calendar register
`default_nettype none

interface dcda_in_if
  import dcda_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               action;
  logic [YEAR_W-1:0]  load_year;
  logic [MONTH_W-1:0] load_month;
  logic [DAY_W-1:0]   load_day;

  modport source (output valid, action, load_year, load_month, load_day, input ready);
  modport sink   (input valid, action, load_year, load_month, load_day, output ready);
endinterface

interface dcda_out_if
  import dcda_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [YEAR_W-1:0]   cur_year;
  logic [MONTH_W-1:0]  cur_month;
  logic [DAY_W-1:0]    cur_day;
  logic [STATUS_W-1:0] status;

  modport source (output valid, cur_year, cur_month, cur_day, status, input ready);
  modport sink   (input valid, cur_year, cur_month, cur_day, status, output ready);
endinterface

interface dcda_cfg_if;
  logic valid;
  logic ready;
  logic calendar_kind;

  modport source (output valid, calendar_kind, input ready);
  modport sink   (input valid, calendar_kind, output ready);
endinterface

`default_nettype wire

FILE: src/dcda_in_reg.sv
// input register stage: captures one item beat and holds it until the step takes it
`default_nettype none

module dcda_in_reg
  import dcda_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dcda_in_if.sink    in_s,
  input  wire logic  take_i,
  output logic       valid_o,
  output item_t      item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  assign in_s.ready = !valid_q || take_i;
  assign load       = in_s.valid && in_s.ready;

  always_comb begin
    valid_d = valid_q;
    if (in_s.ready) begin
      valid_d = in_s.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.action     <= action_e'(in_s.action);
      item_q.load_year  <= in_s.load_year;
      item_q.load_month <= in_s.load_month;
      item_q.load_day   <= in_s.load_day;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

FILE: src/dcda_step.sv
// date step logic: load check or one-day advance against the selected calendar
`default_nettype none

module dcda_step
  import dcda_pkg::*;
(
  input  wire cal_kind_e cal_i,
  input  wire item_t     item_i,
  input  wire date_t     date_i,
  output step_t          res_o
);

  logic [DAY_W-1:0]   ld_len;
  logic [DAY_W:0]     ld_len_p1;
  logic [DAY_W-1:0]   mlen;
  status_e            ld_status;
  status_e            adv_status;
  date_t              adv_date;
  logic               adv_we;

  // load path
  always_comb begin
    ld_len    = common_len(cal_i, item_i.load_month);
    ld_len_p1 = {1'b0, ld_len} + 6'd1;
    ld_status = ST_OK;
    if (item_i.load_month == 4'd0 || item_i.load_month > MONTH_LAST) begin
      ld_status = ST_BAD_MONTH;
    end else if (item_i.load_day == 5'd0) begin
      ld_status = ST_BAD_DAY;
    end else if (item_i.load_year > YEAR_MAX) begin
      ld_status = ST_OVERFLOW;
    end else if (item_i.load_day > ld_len) begin
      if (!leap_month(cal_i, item_i.load_month) || {1'b0, item_i.load_day} != ld_len_p1) begin
        ld_status = ST_DAY_LARGE;
      end else if (!has_leap_day(cal_i, item_i.load_year, item_i.load_month)) begin
        ld_status = ST_LEAP_DAY;
      end
    end
  end

  // advance path
  always_comb begin
    mlen       = common_len(cal_i, date_i.month)
               + DAY_W'(has_leap_day(cal_i, date_i.year, date_i.month));
    adv_date   = date_i;
    adv_status = ST_OK;
    adv_we     = 1'b1;
    if (date_i.day < mlen) begin
      adv_date.day = date_i.day + DAY_ONE;
    end else if (date_i.month >= MONTH_LAST) begin
      if (date_i.year >= YEAR_MAX) begin
        adv_status = ST_OVERFLOW;
        adv_we     = 1'b0;
      end else begin
        adv_date.year  = date_i.year + 14'd1;
        adv_date.month = MONTH_ONE;
        adv_date.day   = DAY_ONE;
      end
    end else begin
      adv_date.month = date_i.month + MONTH_ONE;
      adv_date.day   = DAY_ONE;
    end
  end

  always_comb begin
    if (item_i.action == ACT_ADVANCE) begin
      res_o.we     = adv_we;
      res_o.date   = adv_we ? adv_date : date_i;
      res_o.status = adv_status;
    end else begin
      res_o.we     = ld_status == ST_OK;
      res_o.status = ld_status;
      if (ld_status == ST_OK) begin
        res_o.date.year  = item_i.load_year;
        res_o.date.month = item_i.load_month;
        res_o.date.day   = item_i.load_day;
      end else begin
        res_o.date = date_i;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/dual_calendar_day_advance.sv
// dual calendar day advance: top level with date state, calendar register and result register
//
// usage
//   cfg_i  : one write beat sets calendar_kind (0 jalali, 1 gregorian); always ready;
//            the user writes it only while no item is in flight; the block does not enforce this
//   in_i   : one beat per item; action 0 loads and checks the given date, action 1
//            moves the stored date on by one day
//   out_o  : one result beat per item: the stored date after the item and a status
//            (ok, bad month, bad day, day too large, leap day in common year, overflow)
// timing
//   an accepted item beat passes the input register, then the step logic feeding the
//   result register together with the date state, so the next item already sees the
//   updated date; the step logic is combinational
//   throughput is one item per cycle while out_o is not stalled
// reset
//   date resets to 1401/01/01, calendar to jalali, both stages empty
// backpressure
//   a stalled result holds the result register; the input register keeps one more
//   item, and in_i.ready drops only when both stages are full and out_o is stalled
`default_nettype none

`include "dual_calendar_day_advance_assert.svh"

module dual_calendar_day_advance
  import dcda_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dcda_cfg_if.sink  cfg_i,
  dcda_in_if.sink   in_i,
  dcda_out_if.source out_o
);

  // calendar selection register
  cal_kind_e cal_q;

  // stored date
  date_t date_q, date_d;

  // input stage
  logic  a_valid;
  item_t a_item;
  logic  a_take;

  // result register
  logic    out_valid_q, out_valid_d;
  date_t   out_date_q;
  status_e out_status_q;
  logic    out_load;

  step_t step;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= CAL_JALALI;
    end else if (cfg_i.valid) begin
      cal_q <= cal_kind_e'(cfg_i.calendar_kind);
    end
  end

  dcda_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_s    (in_i),
    .take_i  (a_take),
    .valid_o (a_valid),
    .item_o  (a_item)
  );

  dcda_step u_step (
    .cal_i  (cal_q),
    .item_i (a_item),
    .date_i (date_q),
    .res_o  (step)
  );

  // result register frees up when empty or when its beat is taken this cycle
  assign out_load = !out_valid_q || out_o.ready;
  assign a_take   = a_valid && out_load;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = a_valid;
    end
  end

  // date moves only with the item that enters the result register
  always_comb begin
    date_d = date_q;
    if (a_take && step.we) begin
      date_d = step.date;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      date_q.year   <= YEAR_RST;
      date_q.month  <= MONTH_RST;
      date_q.day    <= DAY_RST;
    end else begin
      out_valid_q <= out_valid_d;
      date_q      <= date_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_take) begin
      out_date_q   <= step.date;
      out_status_q <= step.status;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.cur_year  = out_date_q.year;
  assign out_o.cur_month = out_date_q.month;
  assign out_o.cur_day   = out_date_q.day;
  assign out_o.status    = out_status_q;

  // a stalled result leaves the stored date alone
  `DCDA_ASSERT_NEXT(a_date_hold_on_stall, clk_i, rst_ni, out_valid_q && !out_o.ready,
    $stable(date_q), "date changed while the result beat was stalled")

  // a rejected or overflowing item leaves the stored date alone
  `DCDA_ASSERT_NEXT(a_date_hold_on_error, clk_i, rst_ni, a_take && step.status != ST_OK,
    $stable(date_q), "date changed on an item with error status")

  // both stages full and output stalled means no new item beat
  `DCDA_ASSERT_NOW(a_full_backpressure, clk_i, rst_ni,
    a_valid && out_valid_q && !out_o.ready, !in_i.ready,
    "item beat accepted with both stages full")

endmodule

`default_nettype wire
